@@ rtl/rmf_pkg.sv @@
// Shared types, constants and the CRC-16/Modbus byte step for the RTU frame receiver.
package rmf_pkg;

   // Item codes on the input channel.
   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_TIMEOUT = 1'b1;

   // CRC-16/Modbus: reflected polynomial, all-ones start, no final inversion.
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [15:0] CRC_RESIDUE = 16'h0000;

   // A leading NUL is line noise and is not stored.
   localparam logic [7:0] IDLE_CHAR = 8'h00;

   // Frame lengths are below 256 bytes, so a payload length fits one byte.
   localparam int LEN_W = 8;

   // Width of the payload length reported on the result channel.
   localparam int RSP_LEN_W = 6;

   // Verdict for one frame, passed from the front end to the emitter.
   typedef struct packed {
      logic             good;
      logic             start;
      logic [LEN_W-1:0] len;
   } cmd_type;

   // One byte through the CRC register, one bit per step.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

@@ rtl/rmf_front.sv @@
// Front end: takes bytes and timeouts, keeps the running CRCs and judges each frame.
module rmf_front #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [7:0]                     req_rx_byte,
   output logic                           wr_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           cmd_push,
   output rmf_pkg::cmd_type               cmd,
   input  logic                           cmd_full,
   input  logic                           frame_done
);

   localparam int ADDR_W = $clog2(FRAME_DEPTH);
   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_all_ff, crc_all_in;
   logic [15:0]      crc_skip_ff, crc_skip_in;
   logic             ovf_ff, ovf_in;
   logic             busy_ff, busy_in;
   logic             accept;
   logic             good0;
   logic             good1;

   // The store is owned by the emitter until its run ends, so hold off new items.
   assign req_stall = busy_ff | cmd_full;
   assign accept    = req_valid & ~req_stall;

   // Frame checks, offset 0 taking priority over offset 1.
   assign good0 = ~ovf_ff && (count_ff >= CNT_W'(3)) && (crc_all_ff == rmf_pkg::CRC_RESIDUE);
   assign good1 = ~ovf_ff && (count_ff >= CNT_W'(4)) && (crc_skip_ff == rmf_pkg::CRC_RESIDUE);

   // Next state for the running frame and the verdict pushed on timeout.
   always_comb begin
      count_in    = count_ff;
      crc_all_in  = crc_all_ff;
      crc_skip_in = crc_skip_ff;
      ovf_in      = ovf_ff;
      busy_in     = busy_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[ADDR_W-1:0];
      wr_data     = req_rx_byte;
      cmd_push    = 1'b0;
      cmd         = '0;
      if (frame_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (req_action == rmf_pkg::ACT_BYTE) begin
            if (!(count_ff == '0 && req_rx_byte == rmf_pkg::IDLE_CHAR)) begin
               if (count_ff == CNT_W'(FRAME_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en      = 1'b1;
                  crc_all_in = rmf_pkg::crc_feed(crc_all_ff, req_rx_byte);
                  if (count_ff != '0) begin
                     crc_skip_in = rmf_pkg::crc_feed(crc_skip_ff, req_rx_byte);
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end else begin
            cmd_push = 1'b1;
            if (good0) begin
               cmd.good  = 1'b1;
               cmd.start = 1'b0;
               cmd.len   = rmf_pkg::LEN_W'(count_ff - CNT_W'(2));
            end else if (good1) begin
               cmd.good  = 1'b1;
               cmd.start = 1'b1;
               cmd.len   = rmf_pkg::LEN_W'(count_ff - CNT_W'(3));
            end
            count_in    = '0;
            crc_all_in  = rmf_pkg::CRC_INIT;
            crc_skip_in = rmf_pkg::CRC_INIT;
            ovf_in      = 1'b0;
            busy_in     = 1'b1;
         end
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         crc_all_ff  <= rmf_pkg::CRC_INIT;
         crc_skip_ff <= rmf_pkg::CRC_INIT;
         ovf_ff      <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         crc_all_ff  <= crc_all_in;
         crc_skip_ff <= crc_skip_in;
         ovf_ff      <= ovf_in;
         busy_ff     <= busy_in;
      end
   end

   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FRAME_DEPTH))
      else $error("frame byte count beyond store depth");

   // A timeout transfer leaves an empty frame and a busy front end.
   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == rmf_pkg::ACT_TIMEOUT) |=> (count_ff == '0 && busy_ff && !ovf_ff))
      else $error("frame not cleared after timeout");

endmodule

@@ rtl/rmf_queue.sv @@
// Two-entry command queue between the frame checker and the result emitter.
module rmf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmf_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output rmf_pkg::cmd_type pop_cmd,
   output logic             not_empty
);

   rmf_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue overrun");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command queue underrun");

endmodule

@@ rtl/rmf_back.sv @@
// Back end: frame store and the emitter that walks it to produce result transfers.
module rmf_back #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   input  logic                           cmd_valid,
   input  rmf_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   output logic                           frame_done,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_frame_good,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_start_offset,
   output logic [rmf_pkg::RSP_LEN_W-1:0]  rsp_payload_length,
   output logic                           rsp_last
);

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [7:0]                  store_mem [FRAME_DEPTH];
   logic [7:0]                  rd_data_ff;
   logic [1:0]                  state_ff, state_in;
   logic [ADDR_W-1:0]           addr_ff, addr_in;
   logic [rmf_pkg::LEN_W-1:0]   remain_ff, remain_in;
   logic [rmf_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                        good_ff, good_in;
   logic                        start_ff, start_in;
   logic                        rsp_accept;

   // Result outputs are decoded from registered state alone.
   assign rsp_valid          = (state_ff == ST_EMIT);
   assign rsp_frame_good     = good_ff;
   assign rsp_payload_byte   = good_ff ? rd_data_ff : 8'h00;
   assign rsp_start_offset   = good_ff & start_ff;
   assign rsp_payload_length = good_ff ? len_ff[rmf_pkg::RSP_LEN_W-1:0] : '0;
   assign rsp_last           = ~good_ff | (remain_ff == rmf_pkg::LEN_W'(1));
   assign rsp_accept         = rsp_valid & ~rsp_stall;
   assign frame_done         = rsp_accept & rsp_last;
   assign cmd_pop            = (state_ff == ST_IDLE) & cmd_valid;

   // Emitter: fetch a byte, offer it until taken; a bad report skips the fetch.
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      len_in    = len_ff;
      good_in   = good_ff;
      start_in  = start_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               good_in   = cmd.good;
               start_in  = cmd.start;
               len_in    = cmd.len;
               remain_in = cmd.len;
               addr_in   = ADDR_W'(cmd.start);
               state_in  = cmd.good ? ST_READ : ST_EMIT;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  addr_in   = addr_ff + ADDR_W'(1);
                  remain_in = remain_ff - rmf_pkg::LEN_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
      len_ff    <= len_in;
      good_ff   <= good_in;
      start_ff  <= start_in;
   end

   // Frame store: written by the front end, read by the emitter.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= store_mem[addr_ff];
      end
   end

   // A bad report is a single transfer carrying zero payload fields.
   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_good) |-> (rsp_last && rsp_payload_byte == 8'h00
                                          && rsp_payload_length == '0))
      else $error("bad frame report malformed");

   // The store is never written while a run is in progress.
   a_no_write_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !wr_en)
      else $error("frame store written during emission");

endmodule

@@ rtl/modbus_rtu_frame_receiver.sv @@
// Top level of the Modbus RTU receive deframer with CRC-16/Modbus checking.
// A received byte is stored and its CRC step is registered in the cycle it is accepted.
// After a timeout transfer the verdict passes through the command queue; each payload
// byte then takes a frame store read, then output register, while a bad report skips it.
// A new item is accepted once the last result of the previous timeout has been taken.
// Synchronous reset clears the counts, CRCs and control; the frame store is not cleared.
module modbus_rtu_frame_receiver #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_good,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_start_offset,
   output logic [5:0] rsp_payload_length,
   output logic       rsp_last
);

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              cmd_push;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_valid;
   logic              frame_done;
   rmf_pkg::cmd_type  push_cmd;
   rmf_pkg::cmd_type  pop_cmd;

   // Byte intake and frame checking.
   rmf_front #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .cmd_full    (cmd_full),
      .frame_done  (frame_done)
   );

   // Verdict queue.
   rmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_cmd   (pop_cmd),
      .not_empty (cmd_valid)
   );

   // Frame store and result emission.
   rmf_back #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .cmd_valid          (cmd_valid),
      .cmd                (pop_cmd),
      .cmd_pop            (cmd_pop),
      .frame_done         (frame_done),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_good     (rsp_frame_good),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_start_offset   (rsp_start_offset),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last           (rsp_last)
   );

endmodule

@@ sim/rtu_deframe_checker.sv @@
// Transfer monitor, deframer prediction and result comparison for the RTU frame receiver.
module rtu_deframe_checker #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_frame_good,
   input  logic [7:0] rsp_payload_byte,
   input  logic       rsp_start_offset,
   input  logic [5:0] rsp_payload_length,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // One result as the deframer should present it.
   typedef struct packed {
      logic       good;
      logic [7:0] data;
      logic       offset;
      logic [5:0] length;
      logic       last;
   } frame_result_type;

   frame_result_type awaited_q[$];

   // Shadow of the receive buffer and its running checksums.
   logic [7:0]  held_bytes[FRAME_DEPTH];
   int unsigned held_count = 0;
   logic [15:0] crc_whole  = rmf_pkg::CRC_INIT;
   logic [15:0] crc_tail   = rmf_pkg::CRC_INIT;
   logic        overrun    = 1'b0;
   int          mismatches = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Shift one character through the reflected CRC-16 register.
   function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] octet);
      logic [15:0] r;
      r = crc ^ {8'h00, octet};
      repeat (8) r = r[0] ? ((r >> 1) ^ rmf_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   task automatic forget_frame();
      held_count = 0;
      crc_whole  = rmf_pkg::CRC_INIT;
      crc_tail   = rmf_pkg::CRC_INIT;
      overrun    = 1'b0;
   endtask

   // A received character: leading idle characters are skipped, and a full
   // buffer drops the character and marks the frame as overrun.
   task automatic take_byte(input logic [7:0] octet);
      if (held_count == 0 && octet == rmf_pkg::IDLE_CHAR) begin
         return;
      end
      if (held_count >= FRAME_DEPTH) begin
         overrun = 1'b1;
         return;
      end
      if (held_count != 0) begin
         crc_tail = crc_absorb(crc_tail, octet);
      end
      crc_whole = crc_absorb(crc_whole, octet);
      held_bytes[held_count] = octet;
      held_count++;
   endtask

   // Silence ends the frame: try offset 0, then offset 1, and queue either the
   // payload bytes or a single bad report.
   task automatic close_frame();
      logic             ok;
      logic             origin;
      int unsigned      span;
      frame_result_type r;
      ok     = 1'b0;
      origin = 1'b0;
      span   = 0;
      if (!overrun) begin
         if (held_count >= 3 && crc_whole == rmf_pkg::CRC_RESIDUE) begin
            ok   = 1'b1;
            span = held_count - 2;
         end else if (held_count >= 4 && crc_tail == rmf_pkg::CRC_RESIDUE) begin
            ok     = 1'b1;
            origin = 1'b1;
            span   = held_count - 3;
         end
      end
      if (!ok) begin
         r      = '0;
         r.last = 1'b1;
         awaited_q.push_back(r);
      end else begin
         for (int k = 0; k < span; k++) begin
            r.good   = 1'b1;
            r.data   = held_bytes[origin + k];
            r.offset = origin;
            r.length = 6'(span);
            r.last   = (k == span - 1);
            awaited_q.push_back(r);
         end
      end
      forget_frame();
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      end
   endtask

   // Results are compared before the request of the same edge is predicted;
   // no request can produce a result in the cycle it is taken.
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         awaited_q.delete();
         forget_frame();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: result transfer, expected none, actual payload 0x%0h last %0b",
                        $time, rsp_payload_byte, rsp_last);
            end else begin
               want = awaited_q.pop_front();
               check_field("frame_good", want.good, rsp_frame_good);
               check_field("payload_byte", want.data, rsp_payload_byte);
               check_field("start_offset", want.offset, rsp_start_offset);
               check_field("payload_length", want.length, rsp_payload_length);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == rmf_pkg::ACT_TIMEOUT) begin
               close_frame();
            end else begin
               take_byte(req_rx_byte);
            end
         end
      end
      fail_count <= mismatches;
      pending    <= awaited_q.size();
   end

endmodule

@@ sim/modbus_rtu_frame_receiver_tb.sv @@
// Stimulus, handshake idling and verdict for the Modbus RTU frame receiver.
module modbus_rtu_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 64;
   localparam int ITEM_TARGET  = 180;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   typedef logic [7:0] octet_queue_type[$];

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_action         = rmf_pkg::ACT_BYTE;
   logic [7:0] req_rx_byte        = 8'h00;
   logic       rsp_stall          = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_frame_good;
   logic [7:0] rsp_payload_byte;
   logic       rsp_start_offset;
   logic [5:0] rsp_payload_length;
   logic       rsp_last;

   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int unsigned items_sent  = 0;
   bit          tx_steady   = 1'b0;
   bit          rx_steady   = 1'b0;
   bit          rx_hold_req = 1'b0;

   always #4 clock = ~clock;

   modbus_rtu_frame_receiver #(
      .FRAME_DEPTH(DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_payload_length(rsp_payload_length),
      .rsp_last          (rsp_last)
   );

   rtu_deframe_checker #(
      .FRAME_DEPTH(DEPTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_good    (rsp_frame_good),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_payload_length(rsp_payload_length),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Append the CRC-16/Modbus of the body, low byte first.
   function automatic octet_queue_type seal_frame(input octet_queue_type body);
      logic [15:0]     crc;
      octet_queue_type framed;
      crc = rmf_pkg::CRC_INIT;
      foreach (body[i]) begin
         crc ^= {8'h00, body[i]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ rmf_pkg::CRC_POLY) : (crc >> 1);
      end
      framed = body;
      framed.push_back(crc[7:0]);
      framed.push_back(crc[15:8]);
      return framed;
   endfunction

   function automatic octet_queue_type random_bytes(input int unsigned count);
      octet_queue_type bytes;
      repeat (count) bytes.push_back(8'($urandom_range(0, 255)));
      return bytes;
   endfunction

   // One transfer on the request side. Valid is only lowered when a gap
   // follows, so a back-to-back item never sees valid dropped and raised at once.
   task automatic send_item(input logic act, input logic [7:0] octet);
      int gap;
      if ($urandom_range(0, 11) == 0) begin
         tx_steady = !tx_steady;
      end
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= octet;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_bytes(input octet_queue_type bytes);
      foreach (bytes[i]) send_item(rmf_pkg::ACT_BYTE, bytes[i]);
   endtask

   // The silence timeout; the byte lane carries noise that must be ignored.
   task automatic end_frame();
      send_item(rmf_pkg::ACT_TIMEOUT, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering until every predicted result has been taken.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Result side: a random hold-off before each transfer, stretches with none,
   // and one long hold-off on request from the stimulus.
   initial begin : result_sink
      int wait_cycles;
      @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rx_hold_req = 1'b0;
         end
         if ($urandom_range(0, 11) == 0) begin
            rx_steady = !rx_steady;
         end
         wait_cycles = rx_steady ? 0 : $urandom_range(0, 6);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !rx_hold_req);
      end
   end

   initial begin : stimulus
      octet_queue_type frame;
      int unsigned     kind;
      int unsigned     span;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Silence with nothing stored gives a bad report.
      end_frame();

      // A leading idle character is skipped; then the shortest good frame,
      // carrying an all-ones payload byte.
      send_item(rmf_pkg::ACT_BYTE, rmf_pkg::IDLE_CHAR);
      send_bytes(seal_frame('{8'hFF}));
      end_frame();

      // Two bytes are too short to hold a payload.
      send_bytes('{8'h12, 8'h34});
      end_frame();

      // A stray leading character, then a good frame from offset 1 whose
      // payload starts with a zero byte.
      send_item(rmf_pkg::ACT_BYTE, 8'h80);
      send_bytes(seal_frame('{8'h00, 8'h7F}));
      end_frame();

      // A single flipped bit in the checksum makes the frame bad.
      frame = seal_frame('{8'h55, 8'hAA});
      frame[3] ^= 8'h01;
      send_bytes(frame);
      end_frame();

      // A full buffer with a good checksum; the result side holds off for a
      // long stretch while the next frame is already on offer.
      send_bytes(seal_frame(random_bytes(DEPTH - 2)));
      rx_hold_req = 1'b1;
      end_frame();
      send_bytes(seal_frame(random_bytes(4)));
      end_frame();

      // Characters beyond a full buffer are dropped and the frame is reported bad.
      frame = seal_frame(random_bytes(DEPTH - 2));
      repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
      send_bytes(frame);
      end_frame();
      settle();

      // Random frames, mostly well formed, with noise and damaged frames mixed in.
      while (items_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
         frame = seal_frame(random_bytes(span));
         unique case (kind)
            4, 5: begin
               frame.push_front(8'($urandom_range(1, 255)));
            end
            6: begin
               frame[$urandom_range(0, frame.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            7: begin
               frame = random_bytes($urandom_range(0, 3));
            end
            8: begin
               frame = random_bytes($urandom_range(1, 10));
            end
            9: begin
               repeat ($urandom_range(1, 3)) frame.push_front(rmf_pkg::IDLE_CHAR);
            end
            default: begin
            end
         endcase
         send_bytes(frame);
         end_frame();
         if ($urandom_range(0, 7) == 0) begin
            settle();
         end
      end

      // Drain, then allow time for any stray result to show up.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rmf_pkg.sv
rtl/rmf_front.sv
rtl/rmf_queue.sv
rtl/rmf_back.sv
rtl/modbus_rtu_frame_receiver.sv
sim/rtu_deframe_checker.sv
sim/modbus_rtu_frame_receiver_tb.sv
